[design/chain_length_memo_walker_core_defines.svh]
// ---------------------------------------------------------------------------
// chain length memo walker defines
// assertion macros used by the walker core, the one file that carries checks
// ---------------------------------------------------------------------------
`ifndef CHAIN_LENGTH_MEMO_WALKER_CORE_DEFINES_SVH
`define CHAIN_LENGTH_MEMO_WALKER_CORE_DEFINES_SVH

// antecedent holds, consequent in the same cycle
`define CLMW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clmw check failed");

// antecedent holds, consequent in the next cycle
`define CLMW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clmw check failed");

`endif

[design/clmw_pkg.sv]
// ---------------------------------------------------------------------------
// clmw package
// sizes, opcodes, command and status types of the memo walker
// ---------------------------------------------------------------------------
package clmw_pkg;

   localparam int unsigned MAX_FRAGS = 4095;
   localparam int unsigned ID_W      = 12;
   localparam int unsigned SLOT_W    = ID_W + 1;
   localparam int unsigned CNT_W     = 14;
   localparam int unsigned SLOTS     = 2 * (MAX_FRAGS + 1);
   localparam int unsigned N_W       = $clog2(SLOTS) + 1;
   localparam int unsigned EPOCH_W   = 8;
   localparam int unsigned ID_LIMIT  = (MAX_FRAGS < 4095) ? MAX_FRAGS : 4095;

   localparam logic [CNT_W-1:0]   CMAX      = '1;
   localparam logic [N_W-1:0]     SLOTS_N   = N_W'(SLOTS);
   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(SLOTS - 1);
   localparam logic [ID_W-1:0]    ID_MAX    = ID_W'(ID_LIMIT);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_QUERY,
      CMD_SWEEP,
      CMD_VSWEEP,
      CMD_MEMO_RD,
      CMD_MEMO_HIT,
      CMD_WALK_INIT,
      CMD_LOOP_RD,
      CMD_LOOP_EV,
      CMD_CYC_RD,
      CMD_CYC_EV,
      CMD_REW_INIT,
      CMD_REW_RD,
      CMD_REW_EV,
      CMD_ACCUM,
      CMD_PUT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       memo_clear;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic epoch_full;
      logic memo_hit;
      logic loop_go;
      logic loop_cyc;
      logic cyc_end;
      logic rew_go;
      logic side;
      logic out_free;
      logic fid_ok;
   } status_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CMAX : s[CNT_W-1:0];
   endfunction

   // successor beyond the id range or of fragment zero reads as none
   function automatic logic [SLOT_W-1:0] follow(input logic [SLOT_W-1:0] e);
      logic [ID_W-1:0] id;
      id = e[SLOT_W-1:1];
      return (id > ID_MAX || id == '0) ? '0 : e;
   endfunction

endpackage

[design/clmw_req_if.sv]
// ---------------------------------------------------------------------------
// clmw request interface
// valid/ready channel carrying one request transaction
// ---------------------------------------------------------------------------
interface clmw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [11:0] frag_id;
   logic        frag_end;
   logic [11:0] next_frag;
   logic        next_end;

   modport source (output valid, op, frag_id, frag_end, next_frag, next_end,
                   input ready);
   modport sink   (input valid, op, frag_id, frag_end, next_frag, next_end,
                   output ready);
endinterface

[design/clmw_rsp_if.sv]
// ---------------------------------------------------------------------------
// clmw response interface
// valid/ready channel carrying one result transaction
// ---------------------------------------------------------------------------
interface clmw_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] query_frag;
   logic [13:0] chain_count;

   modport source (output valid, query_frag, chain_count, input ready);
   modport sink   (input valid, query_frag, chain_count, output ready);
endinterface

[design/chain_length_memo_walker_core.sv]
// ---------------------------------------------------------------------------
// chain length memo walker core
// walks successor chains from both ends of a fragment with a length memo
// ---------------------------------------------------------------------------
// usage
//   req: one transaction per request; op load writes a successor entry,
//   op clear zeroes the length memo, op query walks both ends of frag_id
//   rsp: one transaction per query only, query_frag and chain_count
//   a load writes its entry as it is taken; a clear sweeps the memo;
//   a query walks each end, rewrites the walked entries and, in a loop,
//   the loop members, then takes the sum and hands off the result; an
//   end already in the memo is not walked; each walk step waits on a
//   registered read of the memories; every 255 walks the visited tags
//   are swept
//   reset: a sweep clears memo and visited tags, no request is taken meanwhile
//   stall: a result sits in the output register; the next request is taken
//   and a further query holds only its own result until rsp is taken
// ---------------------------------------------------------------------------
`include "chain_length_memo_walker_core_defines.svh"

module chain_length_memo_walker_core
   import clmw_pkg::*;
(
   input logic       clock,
   input logic       reset,
   clmw_req_if.sink  req,
   clmw_rsp_if.source rsp
);

   // command and status between controller and datapath
   cmd_type    cmd;
   status_type status;

   clmw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories and walk registers
   clmw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_frag_id     (req.frag_id),
      .req_frag_end    (req.frag_end),
      .req_next_frag   (req.next_frag),
      .req_next_end    (req.next_end),
      .rsp_ready       (rsp.ready),
      .rsp_valid       (rsp.valid),
      .rsp_query_frag  (rsp.query_frag),
      .rsp_chain_count (rsp.chain_count),
      .status          (status)
   );

   // a load writes only on an accepted transaction
   `CLMW_ASSERT_NOW(a_load_acc, clock, reset, cmd.op == CMD_LOAD, req.valid && req.ready)
   // the output register is loaded only when free
   `CLMW_ASSERT_NOW(a_put_free, clock, reset, cmd.op == CMD_PUT, !rsp.valid || rsp.ready)
   // a query blocks further requests while it runs
   `CLMW_ASSERT_NEXT(a_query_busy, clock, reset,
      req.valid && req.ready && req.op == OP_QUERY, !req.ready)

endmodule

[design/clmw_ctrl.sv]
// ---------------------------------------------------------------------------
// clmw controller
// sequences loads, clears, the two walks of a query and the result hand-off
// ---------------------------------------------------------------------------
module clmw_ctrl
   import clmw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [14:0] {
      ST_SWEEP     = 15'b000000000000001,
      ST_IDLE      = 15'b000000000000010,
      ST_MEMO_RD   = 15'b000000000000100,
      ST_MEMO_CHK  = 15'b000000000001000,
      ST_VSWEEP    = 15'b000000000010000,
      ST_WALK_INIT = 15'b000000000100000,
      ST_LOOP_RD   = 15'b000000001000000,
      ST_LOOP_EV   = 15'b000000010000000,
      ST_CYC_RD    = 15'b000000100000000,
      ST_CYC_EV    = 15'b000001000000000,
      ST_REW_INIT  = 15'b000010000000000,
      ST_REW_RD    = 15'b000100000000000,
      ST_REW_EV    = 15'b001000000000000,
      ST_DONE      = 15'b010000000000000,
      ST_PUT       = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      memo_clr_ff, memo_clr_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      memo_clr_in    = memo_clr_ff;
      cmd.op         = CMD_NONE;
      cmd.memo_clear = memo_clr_ff;
      case (state_ff)
         ST_SWEEP: begin
            cmd.op = CMD_SWEEP;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_LOAD: cmd.op = CMD_LOAD;
                  OP_QUERY: begin
                     cmd.op   = CMD_QUERY;
                     state_in = status.fid_ok ? ST_MEMO_RD : ST_PUT;
                  end
                  OP_CLEAR: begin
                     memo_clr_in = 1'b1;
                     state_in    = ST_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         ST_MEMO_RD: begin
            cmd.op   = CMD_MEMO_RD;
            state_in = ST_MEMO_CHK;
         end
         ST_MEMO_CHK: begin
            if (status.memo_hit) begin
               cmd.op   = CMD_MEMO_HIT;
               state_in = ST_DONE;
            end else if (status.epoch_full) begin
               memo_clr_in = 1'b0;
               state_in    = ST_VSWEEP;
            end else begin
               state_in = ST_WALK_INIT;
            end
         end
         ST_VSWEEP: begin
            cmd.op = CMD_VSWEEP;
            if (status.sweep_last) state_in = ST_WALK_INIT;
         end
         ST_WALK_INIT: begin
            cmd.op   = CMD_WALK_INIT;
            state_in = ST_LOOP_RD;
         end
         ST_LOOP_RD: begin
            cmd.op   = CMD_LOOP_RD;
            state_in = ST_LOOP_EV;
         end
         ST_LOOP_EV: begin
            cmd.op = CMD_LOOP_EV;
            if (status.loop_go)       state_in = ST_LOOP_RD;
            else if (status.loop_cyc) state_in = ST_CYC_RD;
            else                      state_in = ST_REW_INIT;
         end
         ST_CYC_RD: begin
            cmd.op   = CMD_CYC_RD;
            state_in = ST_CYC_EV;
         end
         ST_CYC_EV: begin
            cmd.op   = CMD_CYC_EV;
            state_in = status.cyc_end ? ST_REW_INIT : ST_CYC_RD;
         end
         ST_REW_INIT: begin
            cmd.op   = CMD_REW_INIT;
            state_in = ST_REW_RD;
         end
         ST_REW_RD: begin
            cmd.op   = CMD_REW_RD;
            state_in = status.rew_go ? ST_REW_EV : ST_DONE;
         end
         ST_REW_EV: begin
            cmd.op   = CMD_REW_EV;
            state_in = ST_REW_RD;
         end
         ST_DONE: begin
            cmd.op   = CMD_ACCUM;
            state_in = status.side ? ST_PUT : ST_MEMO_RD;
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.op   = CMD_PUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         memo_clr_ff <= 1'b1;
      end else begin
         state_ff    <= state_in;
         memo_clr_ff <= memo_clr_in;
      end
   end

endmodule

[design/clmw_datapath.sv]
// ---------------------------------------------------------------------------
// clmw datapath
// successor, memo and visited-tag memories with the walk registers
// ---------------------------------------------------------------------------
module clmw_datapath
   import clmw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [ID_W-1:0]   req_frag_id,
   input  logic              req_frag_end,
   input  logic [ID_W-1:0]   req_next_frag,
   input  logic              req_next_end,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_query_frag,
   output logic [CNT_W-1:0]  rsp_chain_count,
   output status_type        status
);

   logic [SLOT_W-1:0]  succ_mem [SLOTS];
   logic [CNT_W-1:0]   memo_mem [SLOTS];
   logic [EPOCH_W-1:0] vtag_mem [SLOTS];

   logic [SLOT_W-1:0]  succ_q;
   logic [CNT_W-1:0]   memo_q;
   logic [EPOCH_W-1:0] vtag_q;

   logic [SLOT_W-1:0]  cur_ff, cur_in, c_ff, c_in, last_ff, last_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, circ_ff, circ_in, res_ff, res_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [SLOT_W-1:0]  sweep_ff, sweep_in;
   logic [ID_W-1:0]    qfid_ff, qfid_in;
   logic               side_ff, side_in;
   logic               valid_ff, valid_in;
   logic [ID_W-1:0]    oqf_ff, oqf_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;

   logic [SLOT_W-1:0]  start_slot, rd_addr, nxt;
   logic [SLOT_W-1:0]  memo_wa, vtag_wa;
   logic [CNT_W-1:0]   memo_wd, cnt_inc;
   logic [EPOCH_W-1:0] vtag_wd;
   logic               memo_we, vtag_we, succ_we;
   logic [N_W-1:0]     n_inc;

   assign start_slot = {qfid_ff, side_ff};
   assign nxt        = follow(succ_q);
   assign cnt_inc    = sat_add(cnt_ff, CNT_W'(1));
   assign n_inc      = n_ff + N_W'(1);

   always_comb begin
      case (cmd.op)
         CMD_MEMO_RD: rd_addr = start_slot;
         CMD_LOOP_RD: rd_addr = cur_ff;
         default:     rd_addr = c_ff;
      endcase
   end

   // status
   always_comb begin
      status.sweep_last = (sweep_ff == SLOT_LAST);
      status.epoch_full = (epoch_ff == EPOCH_MAX);
      status.memo_hit   = (memo_q != '0);
      status.loop_go    = (cur_ff[SLOT_W-1:1] != '0) && (memo_q == '0);
      status.loop_cyc   = (cur_ff[SLOT_W-1:1] != '0) && (vtag_q == epoch_ff);
      status.cyc_end    = (nxt == last_ff) || (n_inc >= SLOTS_N);
      status.rew_go     = (c_ff[SLOT_W-1:1] != last_ff[SLOT_W-1:1]) && (n_ff < SLOTS_N);
      status.side       = side_ff;
      status.out_free   = !valid_ff || rsp_ready;
      status.fid_ok     = (req_frag_id <= ID_MAX) && (req_frag_id != '0);
   end

   // memory write ports
   always_comb begin
      memo_we = 1'b0;
      memo_wa = c_ff;
      memo_wd = cnt_ff;
      vtag_we = 1'b0;
      vtag_wa = cur_ff;
      vtag_wd = epoch_ff;
      succ_we = 1'b0;
      case (cmd.op)
         CMD_LOAD: succ_we = (req_frag_id <= ID_MAX);
         CMD_SWEEP, CMD_VSWEEP: begin
            memo_we = (cmd.op == CMD_SWEEP) && cmd.memo_clear;
            memo_wa = sweep_ff;
            memo_wd = '0;
            vtag_we = 1'b1;
            vtag_wa = sweep_ff;
            vtag_wd = '0;
         end
         CMD_LOOP_EV: begin
            memo_we = status.loop_go;
            memo_wa = cur_ff;
            memo_wd = cnt_inc;
            vtag_we = status.loop_go;
         end
         CMD_CYC_EV: begin
            memo_we = 1'b1;
            memo_wd = circ_ff;
         end
         CMD_REW_EV: memo_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (succ_we) succ_mem[{req_frag_id, req_frag_end}] <= {req_next_frag, req_next_end};
      if (memo_we) memo_mem[memo_wa] <= memo_wd;
      if (vtag_we) vtag_mem[vtag_wa] <= vtag_wd;
      succ_q <= succ_mem[rd_addr];
      memo_q <= memo_mem[rd_addr];
      vtag_q <= vtag_mem[rd_addr];
   end

   // walk registers
   always_comb begin
      cur_in   = cur_ff;
      c_in     = c_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      circ_in  = circ_ff;
      res_in   = res_ff;
      total_in = total_ff;
      n_in     = n_ff;
      epoch_in = epoch_ff;
      sweep_in = sweep_ff;
      qfid_in  = qfid_ff;
      side_in  = side_ff;
      valid_in = valid_ff && !rsp_ready;
      oqf_in   = oqf_ff;
      occ_in   = occ_ff;
      case (cmd.op)
         CMD_SWEEP, CMD_VSWEEP: begin
            sweep_in = sweep_ff + SLOT_W'(1);
            if (status.sweep_last) begin
               sweep_in = '0;
               epoch_in = '0;
            end
         end
         CMD_QUERY: begin
            qfid_in  = req_frag_id;
            side_in  = 1'b0;
            total_in = '0;
         end
         CMD_MEMO_HIT: res_in = memo_q;
         CMD_WALK_INIT: begin
            cur_in   = start_slot;
            cnt_in   = '0;
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
         CMD_LOOP_EV: begin
            if (status.loop_go) begin
               cnt_in = cnt_inc;
               cur_in = nxt;
            end else begin
               last_in = cur_ff;
               c_in    = cur_ff;
               n_in    = '0;
               circ_in = (cnt_ff >= memo_q) ? cnt_ff - memo_q : '0;
               if (!status.loop_cyc && cur_ff[SLOT_W-1:1] != '0)
                  cnt_in = sat_add(cnt_ff, memo_q);
            end
         end
         CMD_CYC_EV: begin
            c_in = nxt;
            n_in = n_inc;
         end
         CMD_REW_INIT: begin
            res_in = cnt_ff;
            c_in   = start_slot;
            n_in   = '0;
         end
         CMD_REW_EV: begin
            if (cnt_ff != '0) cnt_in = cnt_ff - CNT_W'(1);
            c_in = nxt;
            n_in = n_inc;
         end
         CMD_ACCUM: begin
            total_in = sat_add(total_ff, res_ff);
            side_in  = 1'b1;
         end
         CMD_PUT: begin
            valid_in = 1'b1;
            oqf_in   = qfid_ff;
            occ_in   = total_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         epoch_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         epoch_ff <= epoch_in;
         valid_ff <= valid_in;
      end
      cur_ff   <= cur_in;
      c_ff     <= c_in;
      last_ff  <= last_in;
      cnt_ff   <= cnt_in;
      circ_ff  <= circ_in;
      res_ff   <= res_in;
      total_ff <= total_in;
      n_ff     <= n_in;
      qfid_ff  <= qfid_in;
      side_ff  <= side_in;
      oqf_ff   <= oqf_in;
      occ_ff   <= occ_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_query_frag  = oqf_ff;
   assign rsp_chain_count = occ_ff;

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// chain length memo walker testbench
// self-checking bench: a queued driver feeds load, query, clear and unused
// transactions; a monitor compares each result with a predicted one
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
   import clmw_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int NSLOT       = 8192;
   localparam int WATCH_LIMIT = 100000;
   localparam int RAND_ITEMS  = 1330;

   typedef struct {
      logic [1:0]  op;
      logic [11:0] fid;
      logic        fend;
      logic [11:0] nfrag;
      logic        nend;
      bit          drain;   // wait for every outstanding result first
   } req_item_type;

   typedef struct {
      logic [11:0] qfrag;
      logic [13:0] count;
   } chain_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clmw_req_if req ();
   clmw_rsp_if rsp ();

   chain_length_memo_walker_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow state of the walker
   logic [12:0] succ_tab   [NSLOT];
   logic [13:0] memo_len   [NSLOT];
   bit          walk_seen  [NSLOT];
   bit          slot_loaded[NSLOT];

   req_item_type     pending_req[$];
   chain_result_type chain_due[$];

   int  errors      = 0;
   int  query_sent  = 0;
   int  rsp_taken   = 0;
   int  cycle_no    = 0;
   int  quiet_count = 0;

   // no idling on either side through this window
   function automatic bit calm_window();
      return cycle_no > 30000 && cycle_no < 50000;
   endfunction

   function automatic int sat_cnt(input int v);
      return v > 16383 ? 16383 : v;
   endfunction

   function automatic int next_slot(input int s);
      int e;
      e = succ_tab[s];
      if ((e >> 1) == 0) return 0;
      return e;
   endfunction

   // length of the path from one fragment end, with memo write-back
   function automatic int walk_len(input int start);
      int cnt, cur, last, c, n, result, circ;
      cnt = 0;
      cur = start;
      if (memo_len[start] > 0) return memo_len[start];
      foreach (walk_seen[i]) walk_seen[i] = 0;
      while ((cur >> 1) != 0 && memo_len[cur] == 0) begin
         walk_seen[cur] = 1;
         cnt = sat_cnt(cnt + 1);
         memo_len[cur] = 14'(cnt);
         cur = next_slot(cur);
      end
      last = cur;
      if ((last >> 1) != 0 && walk_seen[last]) begin
         // loop found: every member gets the loop length
         circ = cnt >= memo_len[last] ? cnt - memo_len[last] : 0;
         c = last;
         n = 0;
         do begin
            memo_len[c] = 14'(circ);
            c = next_slot(c);
            n++;
         end while (c != last && n < NSLOT);
      end else if ((last >> 1) != 0) begin
         cnt = sat_cnt(cnt + memo_len[last]);
      end
      result = cnt;
      c = start;
      n = 0;
      // rewrite pass stops on fragment id match or after NSLOT steps
      while ((c >> 1) != (last >> 1) && n < NSLOT) begin
         memo_len[c] = 14'(cnt);
         if (cnt > 0) cnt--;
         c = next_slot(c);
         n++;
      end
      return result;
   endfunction

   // true when a walk from this end touches only loaded slots
   function automatic bit walk_defined(input int s);
      int cur;
      cur = s;
      for (int k = 0; k < NSLOT; k++) begin
         if ((cur >> 1) == 0) return 1;
         if (!slot_loaded[cur]) return 0;
         cur = next_slot(cur);
      end
      return 1;
   endfunction

   function automatic bit query_ok(input int f);
      return f == 0 || (walk_defined(2 * f) && walk_defined(2 * f + 1));
   endfunction

   // queue one transaction and update the shadow state
   task automatic push_req(input logic [1:0] op, input int fid, input bit fend,
                           input int nfrag, input bit nend, input bit drain);
      req_item_type     it;
      chain_result_type r;
      int               total;
      it.op = op; it.fid = 12'(fid); it.fend = fend;
      it.nfrag = 12'(nfrag); it.nend = nend; it.drain = drain;
      pending_req.push_back(it);
      case (op)
         OP_LOAD: begin
            succ_tab[2 * fid + fend] = 13'(2 * nfrag + nend);
            slot_loaded[2 * fid + fend] = 1;
         end
         OP_CLEAR: begin
            foreach (memo_len[i]) memo_len[i] = '0;
         end
         OP_QUERY: begin
            total = 0;
            if (fid != 0) begin
               total = walk_len(2 * fid);
               total = sat_cnt(total + walk_len(2 * fid + 1));
            end
            r.qfrag = 12'(fid);
            r.count = 14'(total);
            chain_due.push_back(r);
         end
         default: ;
      endcase
   endtask

   // fragment ids that chains are built from, low and high ends of the range
   function automatic int pool_id();
      int k;
      k = $urandom_range(23);
      return k < 16 ? k + 1 : 4072 + k;
   endfunction

   initial begin
      int f, tries, pick;
      bit found;
      foreach (succ_tab[i]) begin
         succ_tab[i] = '0; memo_len[i] = '0; walk_seen[i] = 0; slot_loaded[i] = 0;
      end

      // directed: self loop, open chain, loop of two, unused op, clear
      push_req(OP_LOAD, 4095, 0, 4095, 0, 0);
      push_req(OP_LOAD, 4095, 1, 0, 1, 0);
      push_req(OP_QUERY, 4095, 0, 0, 0, 0);
      push_req(OP_LOAD, 1, 0, 2, 0, 0);
      push_req(OP_LOAD, 1, 1, 0, 0, 0);
      push_req(OP_LOAD, 2, 0, 3, 1, 0);
      push_req(OP_LOAD, 2, 1, 1, 1, 0);
      push_req(OP_LOAD, 3, 0, 0, 0, 0);
      push_req(OP_LOAD, 3, 1, 0, 0, 0);
      push_req(OP_QUERY, 1, 0, 0, 0, 0);
      push_req(OP_QUERY, 2, 0, 0, 0, 0);
      push_req(OP_QUERY, 3, 0, 0, 0, 0);
      push_req(OP_QUERY, 0, 1, 4095, 1, 0);
      push_req(OP_UNUSED, 4095, 1, 4095, 1, 0);
      push_req(OP_LOAD, 4, 0, 5, 1, 0);
      push_req(OP_LOAD, 4, 1, 0, 0, 0);
      push_req(OP_LOAD, 5, 0, 0, 0, 0);
      push_req(OP_LOAD, 5, 1, 4, 0, 0);
      push_req(OP_QUERY, 4, 0, 0, 0, 1);
      push_req(OP_CLEAR, 0, 0, 0, 0, 0);
      push_req(OP_QUERY, 2, 0, 0, 0, 0);
      push_req(OP_QUERY, 4095, 1, 4095, 1, 0);

      // random: mostly chain building and queries, some noise
      for (int i = 0; i < RAND_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 44) begin
            f = $urandom_range(9) == 0 ? $urandom_range(4095) : pool_id();
            case ($urandom_range(19))
               0, 1, 2, 3, 4: push_req(OP_LOAD, f, $urandom_range(1), 0,
                                       $urandom_range(1), 0);
               5:             push_req(OP_LOAD, f, $urandom_range(1),
                                       $urandom_range(4095), $urandom_range(1), 0);
               default:       push_req(OP_LOAD, f, $urandom_range(1), pool_id(),
                                       $urandom_range(1), 0);
            endcase
         end else if (pick < 96) begin
            found = 0;
            for (tries = 0; tries < 8 && !found; tries++) begin
               f = pool_id();
               found = query_ok(f);
            end
            if (!found) f = 0;
            push_req(OP_QUERY, f, $urandom_range(1), $urandom_range(4095),
                     $urandom_range(1), i == 700);
         end else if (pick < 98) begin
            push_req(OP_CLEAR, $urandom_range(4095), $urandom_range(1),
                     $urandom_range(4095), $urandom_range(1), 0);
         end else begin
            push_req(OP_UNUSED, $urandom_range(4095), $urandom_range(1),
                     $urandom_range(4095), $urandom_range(1), 0);
         end
      end

      wait (pending_req.size() == 0 && chain_due.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("PASS chain_length_memo_walker_core");
      end else begin
         $display("FAIL chain_length_memo_walker_core");
      end
      $finish;
   end

   // reset once at the start
   initial begin
      req.valid = 1'b0; req.op = OP_LOAD; req.frag_id = '0; req.frag_end = 1'b0;
      req.next_frag = '0; req.next_end = 1'b0;
      rsp.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (req.valid && req.ready) begin
            if (pending_req[0].op == OP_QUERY) query_sent++;
            void'(pending_req.pop_front());
         end
         if (pending_req.size() != 0
             && !(pending_req[0].drain && query_sent != rsp_taken)
             && (calm_window() || $urandom_range(99) >= 30)) begin
            req.valid     <= 1'b1;
            req.op        <= pending_req[0].op;
            req.frag_id   <= pending_req[0].fid;
            req.frag_end  <= pending_req[0].fend;
            req.next_frag <= pending_req[0].nfrag;
            req.next_end  <= pending_req[0].nend;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      chain_result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= calm_window() || $urandom_range(99) >= 30;
         if (rsp.valid && rsp.ready) begin
            rsp_taken++;
            if (chain_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result frag %0d count %0d", $time,
                        rsp.query_frag, rsp.chain_count);
            end else begin
               want = chain_due.pop_front();
               if (rsp.query_frag !== want.qfrag) begin
                  errors++;
                  $display("%0t: query_frag expected %0d actual %0d", $time,
                           want.qfrag, rsp.query_frag);
               end
               if (rsp.chain_count !== want.count) begin
                  errors++;
                  $display("%0t: chain_count expected %0d actual %0d", $time,
                           want.count, rsp.chain_count);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCH_LIMIT) begin
         $display("FAIL chain_length_memo_walker_core");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

endmodule
